// ----- src/rct_pkg.sv -----
`default_nettype none
package rct_pkg;

   localparam int FieldLimit = 32;
   localparam int CountBits  = 32;
   localparam int TallyBits  = 16;
   localparam int MaxRes     = 3;

   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChVt     = 8'h0B;
   localparam logic [7:0] ChFf     = 8'h0C;
   localparam logic [7:0] ChPlus   = 8'h2B;
   localparam logic [7:0] ChMinus  = 8'h2D;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_DONE_TK = 2'd1,
      KIND_DISCARD = 2'd2,
      KIND_MSG_END = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_DOLLAR  = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_SKIP    = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       msg_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  out_kind;
      logic [15:0] tokens_found;
      logic        stopped_early;
      logic        run_last;
   } rsp_type;

   // classified beat handed from front to back: up to three results
   typedef struct packed {
      logic [MaxRes-1:0] valid;
      rsp_type [MaxRes-1:0] res;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
                 (c == ChFf) || (c == ChCr);
   endfunction

endpackage
`default_nettype wire

// ----- src/rct_front.sv -----
`default_nettype none
module rct_front #(
   parameter int FIELD_LIMIT = rct_pkg::FieldLimit,
   parameter int COUNT_BITS  = rct_pkg::CountBits,
   parameter int TALLY_BITS  = rct_pkg::TallyBits
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                beat_in,
   input  wire rct_pkg::req_type    req,
   output rct_pkg::bundle_type      bundle
);

   localparam int FcBits = $clog2(FIELD_LIMIT + 1);
   localparam logic [COUNT_BITS-1:0] CountMax = '1;
   localparam logic [TALLY_BITS-1:0] TallyMax = '1;
   // largest accumulator that can still take a digit without saturating
   localparam logic [COUNT_BITS-1:0] AccLim = CountMax / 10;
   localparam logic [3:0] LimDigit = 4'(CountMax - AccLim * 10);

   // parser state
   logic                  first_ff, first_in;
   logic                  split_ff, split_in;
   rct_pkg::phase_type    phase_ff, phase_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic [FcBits-1:0]     fc_ff, fc_in;
   logic                  sign_ff, sign_in, dig_ff, dig_in, bad_ff, bad_in, neg_ff, neg_in;
   logic                  cr_ff, cr_in;
   logic [COUNT_BITS-1:0] elem_ff, elem_in;
   logic [COUNT_BITS-1:0] pay_ff, pay_in;
   logic                  skip_ff, skip_in;
   logic [TALLY_BITS-1:0] tally_ff, tally_in;
   logic                  tok_ff, tok_in;
   logic                  halt_ff, halt_in;

   // feed one character to the number line
   function automatic void fchar(input logic [7:0] c, inout logic [COUNT_BITS-1:0] a,
                                 inout logic [FcBits-1:0] n, inout logic s,
                                 inout logic d, inout logic b, inout logic ng);
      logic [3:0] dv;
      dv = 4'(c - rct_pkg::ChZero);
      if (n < FcBits'(FIELD_LIMIT)) n = n + 1'b1;
      if (!b) begin
         if (c >= rct_pkg::ChZero && c <= rct_pkg::ChNine) begin
            d = 1'b1;
            if (a > AccLim || (a == AccLim && dv > LimDigit)) a = CountMax;
            else a = COUNT_BITS'(a * 10) + COUNT_BITS'(dv);
         end else if (d || s) begin
            b = 1'b1;
         end else if (rct_pkg::is_space(c)) begin
            b = b;
         end else if (c == rct_pkg::ChPlus || c == rct_pkg::ChMinus) begin
            s = 1'b1;
            if (c == rct_pkg::ChMinus) ng = 1'b1;
         end else begin
            b = 1'b1;
         end
      end
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       ok;
      logic [1:0] k;
      logic       stop;
      logic [COUNT_BITS-1:0] v;
      first_in = first_ff; split_in = split_ff; phase_in = phase_ff; acc_in = acc_ff;
      fc_in = fc_ff; sign_in = sign_ff; dig_in = dig_ff; bad_in = bad_ff; neg_in = neg_ff;
      cr_in = cr_ff; elem_in = elem_ff; pay_in = pay_ff; skip_in = skip_ff;
      tally_in = tally_ff; tok_in = tok_ff; halt_in = halt_ff;
      bundle = '0;
      c = req.in_byte;
      k = '0;
      ok = 1'b0;
      stop = 1'b0;
      v = '0;
      if (beat_in) begin
         if (first_ff && c == rct_pkg::ChStar) begin
            first_in = 1'b0;
         end else if (first_ff || split_ff) begin
            // whitespace splitting
            first_in = 1'b0;
            split_in = 1'b1;
            if (rct_pkg::is_space(c)) begin
               if (tok_ff) begin
                  if (tally_in != TallyMax) tally_in = tally_in + 1'b1;
                  tok_in = 1'b0;
                  bundle.valid[k] = 1'b1;
                  bundle.res[k].out_kind = rct_pkg::KIND_DONE_TK;
                  bundle.res[k].tokens_found = 16'(tally_in);
                  k = k + 1'b1;
               end
            end else begin
               tok_in = 1'b1;
               bundle.valid[k] = 1'b1;
               bundle.res[k].out_byte = c;
               bundle.res[k].out_kind = rct_pkg::KIND_BYTE;
               bundle.res[k].tokens_found = 16'(tally_in);
               k = k + 1'b1;
            end
         end else if (!halt_ff && phase_ff != rct_pkg::PH_DONE) begin
            case (phase_ff)
               rct_pkg::PH_HEADER, rct_pkg::PH_LENGTH: begin
                  if (cr_ff) begin
                     if (c == rct_pkg::ChLf) begin
                        // line end
                        ok = dig_ff && !bad_ff && fc_ff < FcBits'(FIELD_LIMIT) &&
                             !(neg_ff && acc_ff != '0);
                        v = acc_ff;
                        acc_in = '0; fc_in = '0; sign_in = 1'b0; dig_in = 1'b0;
                        bad_in = 1'b0; neg_in = 1'b0; cr_in = 1'b0;
                        if (!ok) begin
                           halt_in = 1'b1;
                        end else if (phase_ff == rct_pkg::PH_HEADER) begin
                           elem_in = v;
                           phase_in = (v == '0) ? rct_pkg::PH_DONE : rct_pkg::PH_DOLLAR;
                        end else begin
                           pay_in = v;
                           tok_in = 1'b1;
                           phase_in = rct_pkg::PH_PAYLOAD;
                           if (v == '0) begin
                              if (tally_in != TallyMax) tally_in = tally_in + 1'b1;
                              tok_in = 1'b0;
                              bundle.valid[k] = 1'b1;
                              bundle.res[k].out_kind = rct_pkg::KIND_DONE_TK;
                              bundle.res[k].tokens_found = 16'(tally_in);
                              k = k + 1'b1;
                              elem_in = elem_ff - 1'b1;
                              if (elem_in == '0) phase_in = rct_pkg::PH_DONE;
                              else begin
                                 phase_in = rct_pkg::PH_SKIP;
                                 skip_in = 1'b0;
                              end
                           end
                        end
                     end else begin
                        fchar(rct_pkg::ChCr, acc_in, fc_in, sign_in, dig_in, bad_in, neg_in);
                        if (c != rct_pkg::ChCr) begin
                           cr_in = 1'b0;
                           fchar(c, acc_in, fc_in, sign_in, dig_in, bad_in, neg_in);
                        end
                     end
                  end else if (c == rct_pkg::ChCr) begin
                     cr_in = 1'b1;
                  end else begin
                     fchar(c, acc_in, fc_in, sign_in, dig_in, bad_in, neg_in);
                  end
               end
               rct_pkg::PH_DOLLAR: begin
                  if (c == rct_pkg::ChDollar) begin
                     acc_in = '0; fc_in = '0; sign_in = 1'b0; dig_in = 1'b0;
                     bad_in = 1'b0; neg_in = 1'b0; cr_in = 1'b0;
                     phase_in = rct_pkg::PH_LENGTH;
                  end else begin
                     halt_in = 1'b1;
                  end
               end
               rct_pkg::PH_PAYLOAD: begin
                  bundle.valid[k] = 1'b1;
                  bundle.res[k].out_byte = c;
                  bundle.res[k].out_kind = rct_pkg::KIND_BYTE;
                  bundle.res[k].tokens_found = 16'(tally_in);
                  k = k + 1'b1;
                  pay_in = pay_ff - 1'b1;
                  if (pay_in == '0) begin
                     if (tally_in != TallyMax) tally_in = tally_in + 1'b1;
                     tok_in = 1'b0;
                     bundle.valid[k] = 1'b1;
                     bundle.res[k].out_kind = rct_pkg::KIND_DONE_TK;
                     bundle.res[k].tokens_found = 16'(tally_in);
                     k = k + 1'b1;
                     elem_in = elem_ff - 1'b1;
                     if (elem_in == '0) phase_in = rct_pkg::PH_DONE;
                     else begin
                        phase_in = rct_pkg::PH_SKIP;
                        skip_in = 1'b0;
                     end
                  end
               end
               rct_pkg::PH_SKIP: begin
                  // first skip byte sets the flag, second returns to '$'
                  if (skip_ff) phase_in = rct_pkg::PH_DOLLAR;
                  skip_in = 1'b1;
               end
               default: halt_in = 1'b1;
            endcase
         end

         // message end
         if (req.msg_last) begin
            if (split_in) begin
               if (tok_in) begin
                  if (tally_in != TallyMax) tally_in = tally_in + 1'b1;
                  bundle.valid[k] = 1'b1;
                  bundle.res[k].out_kind = rct_pkg::KIND_DONE_TK;
                  bundle.res[k].tokens_found = 16'(tally_in);
                  k = k + 1'b1;
               end
            end else begin
               if (!halt_in && phase_in == rct_pkg::PH_PAYLOAD && tok_in) begin
                  bundle.valid[k] = 1'b1;
                  bundle.res[k].out_kind = rct_pkg::KIND_DISCARD;
                  bundle.res[k].tokens_found = 16'(tally_in);
                  k = k + 1'b1;
               end
               stop = halt_in || phase_in != rct_pkg::PH_DONE;
            end
            bundle.valid[k] = 1'b1;
            bundle.res[k].out_kind = rct_pkg::KIND_MSG_END;
            bundle.res[k].tokens_found = 16'(tally_in);
            bundle.res[k].stopped_early = stop;
            first_in = 1'b1; split_in = 1'b0; phase_in = rct_pkg::PH_HEADER;
            acc_in = '0; fc_in = '0; sign_in = 1'b0; dig_in = 1'b0; bad_in = 1'b0;
            neg_in = 1'b0; cr_in = 1'b0; elem_in = '0; pay_in = '0; skip_in = 1'b0;
            tally_in = '0; tok_in = 1'b0; halt_in = 1'b0;
         end
         if (bundle.valid[2]) bundle.res[2].run_last = 1'b1;
         else if (bundle.valid[1]) bundle.res[1].run_last = 1'b1;
         else if (bundle.valid[0]) bundle.res[0].run_last = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1; split_ff <= 1'b0; phase_ff <= rct_pkg::PH_HEADER;
         acc_ff <= '0; fc_ff <= '0; sign_ff <= 1'b0; dig_ff <= 1'b0; bad_ff <= 1'b0;
         neg_ff <= 1'b0; cr_ff <= 1'b0; elem_ff <= '0; pay_ff <= '0; skip_ff <= 1'b0;
         tally_ff <= '0; tok_ff <= 1'b0; halt_ff <= 1'b0;
      end else begin
         first_ff <= first_in; split_ff <= split_in; phase_ff <= phase_in;
         acc_ff <= acc_in; fc_ff <= fc_in; sign_ff <= sign_in; dig_ff <= dig_in;
         bad_ff <= bad_in; neg_ff <= neg_in; cr_ff <= cr_in; elem_ff <= elem_in;
         pay_ff <= pay_in; skip_ff <= skip_in; tally_ff <= tally_in; tok_ff <= tok_in;
         halt_ff <= halt_in;
      end
   end

   // split mode and array parsing never hold together
   assert property (@(posedge clock) disable iff (reset)
      split_ff |-> phase_ff == rct_pkg::PH_HEADER)
      else $error("split mode with array phase");
   // results are packed from the bottom
   assert property (@(posedge clock) disable iff (reset)
      bundle.valid[1] |-> bundle.valid[0])
      else $error("bundle has a hole");
   // payload phase always has an open token
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == rct_pkg::PH_PAYLOAD |-> tok_ff && pay_ff != '0)
      else $error("payload phase without token");

endmodule
`default_nettype wire

// ----- src/rct_back.sv -----
`default_nettype none
module rct_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                bundle_push,
   input  wire rct_pkg::bundle_type bundle,
   output logic                     full,
   output logic                     empty,
   input  wire logic                pop,
   output rct_pkg::rsp_type         rsp
);

   // two-entry bundle queue, then results unpacked one per pop
   rct_pkg::bundle_type q_ff [2];
   rct_pkg::bundle_type q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic       do_push, do_pop, head_done;
   logic [rct_pkg::MaxRes-1:0] rem;

   assign do_push = bundle_push && bundle.valid != '0;
   assign empty   = cnt_ff == 2'd0;
   assign full    = cnt_ff == 2'd2;
   assign rsp     = q_ff[0].res[sel_ff];
   assign do_pop  = pop && !empty;
   assign rem     = q_ff[0].valid >> (sel_ff + 2'd1);
   assign head_done = do_pop && rem[0] == 1'b0;

   always_comb begin
      q0_in = q_ff[0]; q1_in = q_ff[1]; cnt_in = cnt_ff; sel_in = sel_ff;
      if (do_pop) sel_in = head_done ? 2'd0 : sel_ff + 2'd1;
      if (head_done) begin
         q0_in = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (do_push) begin
         if (cnt_in == 2'd0) q0_in = bundle;
         else q1_in = bundle;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sel_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
      end
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> q_ff[0].valid[sel_ff])
      else $error("head points at empty slot");
   assert property (@(posedge clock) disable iff (reset)
      head_done |-> rsp.run_last)
      else $error("bundle retired without last mark");

endmodule
`default_nettype wire

// ----- src/resp_command_tokenizer.sv -----
`default_nettype none
// A byte's results are registered in the bundle queue and read from its head on rsp_data.
// Throughput: one byte a cycle; a byte causing n results holds the result side
// for n pops, and the two-deep bundle queue stalls input only when it is full.
// Reset (synchronous, active high) clears the parser to await a message's first byte
// and empties the queue.
module resp_command_tokenizer #(
   parameter int FIELD_LIMIT = rct_pkg::FieldLimit,
   parameter int COUNT_BITS  = rct_pkg::CountBits,
   parameter int TALLY_BITS  = rct_pkg::TallyBits
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire rct_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rct_pkg::rsp_type      rsp_data
);

   rct_pkg::bundle_type bundle;
   logic beat_in;

   assign beat_in = req_push && !req_full;

   rct_front #(
      .FIELD_LIMIT(FIELD_LIMIT), .COUNT_BITS(COUNT_BITS), .TALLY_BITS(TALLY_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .beat_in(beat_in), .req(req_data), .bundle(bundle)
   );

   rct_back u_back (
      .clock(clock), .reset(reset), .bundle_push(beat_in), .bundle(bundle),
      .full(req_full), .empty(rsp_empty), .pop(rsp_pop), .rsp(rsp_data)
   );

endmodule
`default_nettype wire

// ----- tb/tb_resp_command_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_resp_command_tokenizer;

   localparam int COUNT_BITS = rct_pkg::CountBits;
   localparam int TALLY_BITS = rct_pkg::TallyBits;
   localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [63:0] TALLY_TOP = (64'd1 << TALLY_BITS) - 64'd1;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   rct_pkg::req_type req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   rct_pkg::rsp_type rsp_data;

   resp_command_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   rct_pkg::req_type pending_bytes[$];
   rct_pkg::rsp_type expected_tokens[$];
   int               fault_count = 0;

   // tokenizer state held alongside the block
   bit                 m_first, m_split, m_cr, m_in_tok, m_halt;
   rct_pkg::phase_type m_phase;
   logic [63:0]        m_accum, m_elems, m_payload, m_tally;
   int                 m_chars;
   bit                 f_sign, f_digit, f_bad, f_neg;
   int                 m_skip;

   // handshake bookkeeping
   bit took_beat;
   int gap_left;
   int stall_left;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic bit blank(input logic [7:0] c);
      return c == rct_pkg::ChSpace || c == rct_pkg::ChTab || c == rct_pkg::ChLf ||
             c == rct_pkg::ChVt || c == rct_pkg::ChFf || c == rct_pkg::ChCr;
   endfunction

   function automatic void clear_line();
      m_accum = 0; m_chars = 0; f_sign = 0; f_digit = 0; f_bad = 0; f_neg = 0; m_cr = 0;
   endfunction

   function automatic void tok_reset();
      m_first = 1; m_split = 0; m_phase = rct_pkg::PH_HEADER; clear_line();
      m_elems = 0; m_payload = 0; m_skip = 0; m_tally = 0; m_in_tok = 0; m_halt = 0;
   endfunction

   function automatic void post(input logic [7:0] b, input rct_pkg::kind_type k,
                                input bit stop);
      rct_pkg::rsp_type r;
      r.out_byte = b; r.out_kind = k; r.tokens_found = m_tally[15:0];
      r.stopped_early = stop; r.run_last = 1'b0;
      expected_tokens.push_back(r);
   endfunction

   function automatic void commit_tok();
      if (m_tally < TALLY_TOP) m_tally++;
      m_in_tok = 0;
      post(8'h00, rct_pkg::KIND_DONE_TK, 1'b0);
   endfunction

   function automatic void element_end();
      commit_tok();
      m_elems--;
      if (m_elems == 0) m_phase = rct_pkg::PH_DONE;
      else begin
         m_phase = rct_pkg::PH_SKIP; m_skip = 2;
      end
   endfunction

   function automatic void line_char(input logic [7:0] c);
      logic [63:0] d;
      if (m_chars < rct_pkg::FieldLimit) m_chars++;
      if (!f_bad) begin
         if (c >= rct_pkg::ChZero && c <= rct_pkg::ChNine) begin
            d = 64'(c - rct_pkg::ChZero);
            f_digit = 1;
            if (m_accum > (COUNT_TOP - d) / 10) m_accum = COUNT_TOP;
            else m_accum = m_accum * 10 + d;
         end else if (f_digit || f_sign) begin
            f_bad = 1;
         end else if (c == rct_pkg::ChPlus || c == rct_pkg::ChMinus) begin
            f_sign = 1;
            if (c == rct_pkg::ChMinus) f_neg = 1;
         end else if (!blank(c)) begin
            // leading whitespace is skipped, anything else spoils the line
            f_bad = 1;
         end
      end
   endfunction

   function automatic void line_done();
      bit ok;
      logic [63:0] v;
      rct_pkg::phase_type ph;
      ok = f_digit && !f_bad && m_chars < rct_pkg::FieldLimit && !(f_neg && m_accum != 0);
      v = m_accum; ph = m_phase;
      clear_line();
      if (!ok) begin
         m_halt = 1;
      end else if (ph == rct_pkg::PH_HEADER) begin
         m_elems = v;
         m_phase = (v == 0) ? rct_pkg::PH_DONE : rct_pkg::PH_DOLLAR;
      end else begin
         m_payload = v; m_in_tok = 1; m_phase = rct_pkg::PH_PAYLOAD;
         if (v == 0) element_end();
      end
   endfunction

   function automatic void array_byte(input logic [7:0] c);
      if (m_halt || m_phase == rct_pkg::PH_DONE) return;
      case (m_phase)
         rct_pkg::PH_HEADER, rct_pkg::PH_LENGTH: begin
            if (m_cr) begin
               if (c == rct_pkg::ChLf) begin
                  m_cr = 0; line_done();
               end else begin
                  line_char(rct_pkg::ChCr);
                  if (c != rct_pkg::ChCr) begin
                     m_cr = 0; line_char(c);
                  end
               end
            end else if (c == rct_pkg::ChCr) m_cr = 1;
            else line_char(c);
         end
         rct_pkg::PH_DOLLAR: begin
            if (c == rct_pkg::ChDollar) begin
               clear_line(); m_phase = rct_pkg::PH_LENGTH;
            end else m_halt = 1;
         end
         rct_pkg::PH_PAYLOAD: begin
            post(c, rct_pkg::KIND_BYTE, 1'b0);
            m_payload--;
            if (m_payload == 0) element_end();
         end
         rct_pkg::PH_SKIP: begin
            m_skip--;
            if (m_skip == 0) m_phase = rct_pkg::PH_DOLLAR;
         end
         default: m_halt = 1;
      endcase
   endfunction

   function automatic void split_step(input logic [7:0] c);
      if (blank(c)) begin
         if (m_in_tok) commit_tok();
      end else begin
         m_in_tok = 1; post(c, rct_pkg::KIND_BYTE, 1'b0);
      end
   endfunction

   // works out the results of one accepted byte
   function automatic void tokenize_byte(input rct_pkg::req_type q);
      int n0;
      bit stop;
      n0 = expected_tokens.size();
      if (m_first) begin
         m_first = 0;
         if (q.in_byte == rct_pkg::ChStar) begin
            m_split = 0; m_phase = rct_pkg::PH_HEADER; clear_line();
         end else begin
            m_split = 1; split_step(q.in_byte);
         end
      end else if (m_split) split_step(q.in_byte);
      else array_byte(q.in_byte);
      if (q.msg_last) begin
         if (m_split) begin
            if (m_in_tok) commit_tok();
            stop = 0;
         end else begin
            if (!m_halt && m_phase == rct_pkg::PH_PAYLOAD && m_in_tok) begin
               m_in_tok = 0; post(8'h00, rct_pkg::KIND_DISCARD, 1'b0);
            end
            stop = m_halt || m_phase != rct_pkg::PH_DONE;
         end
         post(8'h00, rct_pkg::KIND_MSG_END, stop);
         tok_reset();
      end
      if (expected_tokens.size() > n0)
         expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fault_count++;
   endtask

   // stimulus building
   task automatic put_byte(input logic [7:0] b, input bit last);
      rct_pkg::req_type q;
      q.in_byte = b; q.msg_last = last;
      pending_bytes.push_back(q);
   endtask

   task automatic put_text(input string s, input bit end_msg);
      for (int i = 0; i < s.len(); i++) put_byte(s[i], end_msg && i == s.len() - 1);
   endtask

   task automatic put_array(input int elems, input int maxlen, input bit noisy);
      int len;
      int cut;
      cut = noisy ? int'($urandom_range(0, 3)) : 0;
      put_text($sformatf("*%0d\r\n", elems), 1'b0);
      for (int e = 0; e < elems; e++) begin
         len = int'($urandom_range(0, maxlen));
         if (noisy && $urandom_range(0, 5) == 0)
            put_text($sformatf("$%s%0d\r\n", ($urandom_range(0, 1) ? " +" : ""), len), 1'b0);
         else put_text($sformatf("$%0d\r\n", len), 1'b0);
         for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
         // message cut short inside the last payload
         if (cut == 1 && e == elems - 1 && len > 1) begin
            void'(pending_bytes.pop_back());
            pending_bytes[pending_bytes.size() - 1].msg_last = 1'b1;
            return;
         end
         if (e != elems - 1) begin
            put_byte(8'($urandom_range(0, 255)), 1'b0);
            put_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      if (cut == 2) put_byte(rct_pkg::ChDollar, 1'b0);
      put_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 25)) :
                                           int'($urandom_range(0, 1));
   endfunction

   // input beats taken at the rising edge
   always @(posedge clock) begin
      took_beat <= !reset && req_push && !req_full;
      if (!reset && req_push && !req_full) tokenize_byte(pending_bytes.pop_front());
   end

   // driver: changes on the falling edge, holds a beat until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (req_push && !took_beat) begin
         // beat still waiting
      end else if (gap_left > 0) begin
         req_push <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_bytes.size() > 0 && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         gap_left <= pick_gap();
      end else if (pending_bytes.size() > 0) begin
         req_push <= 1'b1;
         req_data <= pending_bytes[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // pop with random stalls, mostly short
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_pop <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30)) :
                                                      int'($urandom_range(0, 1));
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // monitor: check each result beat
   always @(posedge clock) begin
      rct_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_tokens.size() == 0) report("result beat with nothing expected");
         else begin
            want = expected_tokens.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report($sformatf("out_byte %h want %h", rsp_data.out_byte, want.out_byte));
            if (rsp_data.out_kind !== want.out_kind)
               report($sformatf("out_kind %0d want %0d", rsp_data.out_kind, want.out_kind));
            if (rsp_data.tokens_found !== want.tokens_found)
               report($sformatf("tokens_found %0d want %0d",
                                rsp_data.tokens_found, want.tokens_found));
            if (rsp_data.stopped_early !== want.stopped_early)
               report($sformatf("stopped_early %0b want %0b",
                                rsp_data.stopped_early, want.stopped_early));
            if (rsp_data.run_last !== want.run_last)
               report($sformatf("run_last %0b want %0b", rsp_data.run_last, want.run_last));
         end
      end
   end

   initial begin
      int kind;
      tok_reset();
      reset = 1;
      // directed messages
      put_text("*2\r\n$3\r\nSET\r\n$0\r\n\r\n", 1'b1);
      put_text("*0\r\n", 1'b1);
      put_text("*-0\r\n", 1'b1);
      put_text("*-1\r\n", 1'b1);
      put_text("* +1\r\n$2\r\nab", 1'b1);
      put_text("*1\r\n$5\r\nab", 1'b1);
      put_text("*1\r\nx", 1'b1);
      put_text("*1\r\r\n", 1'b1);
      put_text("*99999999999\r\n", 1'b1);
      put_text("*000000000000000000000000000000001\r\n", 1'b1);
      put_text("ping  a\tb", 1'b1);
      put_byte(8'hFF, 1'b1);
      put_byte(8'h00, 1'b1);
      put_byte(rct_pkg::ChStar, 1'b1);
      put_text(" \n", 1'b1);
      // random part
      while (pending_bytes.size() < 460) begin
         kind = int'($urandom_range(0, 9));
         if (kind < 6) put_array(int'($urandom_range(1, 4)), 6, kind > 3);
         else if (kind < 8) begin
            for (int i = int'($urandom_range(1, 12)); i > 0; i--)
               put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                        ($urandom_range(0, 1) ? rct_pkg::ChSpace : rct_pkg::ChTab), i == 1);
         end else begin
            put_byte(rct_pkg::ChStar, 1'b0);
            for (int i = int'($urandom_range(1, 8)); i > 0; i--)
               put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rct_pkg::ChCr,
                        i == 1);
         end
      end
      repeat (6) @(posedge clock);
      @(negedge clock) reset = 0;
      wait (pending_bytes.size() == 0 && expected_tokens.size() == 0);
      repeat (20) @(posedge clock);
      if (fault_count == 0 && expected_tokens.size() == 0 && rsp_empty) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
